FILE: rtl/full_circle_vector_angle_unit_macros.svh
// Assertion macros for the full circle vector angle unit.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef FULL_CIRCLE_VECTOR_ANGLE_UNIT_MACROS_SVH
`define FULL_CIRCLE_VECTOR_ANGLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FCVA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcva assertion failed");

// Next-cycle implication, checked out of reset.
`define FCVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcva assertion failed");

`endif

FILE: rtl/fcva_pkg.sv
// Shared types and constants of the full circle vector angle unit.
// Used by the input stage, the CORDIC cells, the rounding stage and the top level.
package fcva_pkg;

    localparam int GUARD_SHIFT = 16;
    localparam int TABLE_LEN   = 24;
    localparam int Z_BITS      = 29;
    localparam int ANGLE_BITS  = 16;
    localparam int ROUND_SHIFT = 11;
    localparam int Q_BITS      = Z_BITS - ROUND_SHIFT;

    localparam logic signed [Z_BITS-1:0] PI_Q24     = 29'sd52707179;
    localparam logic signed [Z_BITS-1:0] TWO_PI_Q24 = 29'sd105414357;
    localparam logic signed [Z_BITS-1:0] ROUND_BIAS = 29'sd1024;

    localparam logic [ANGLE_BITS-1:0] HALF_PI_Q13       = 16'd12868;
    localparam logic [ANGLE_BITS-1:0] PI_Q13            = 16'd25736;
    localparam logic [ANGLE_BITS-1:0] THREE_HALF_PI_Q13 = 16'd38604;
    localparam logic [ANGLE_BITS-1:0] ZERO_Q13          = 16'd0;
    localparam logic [Q_BITS-1:0]     FULL_TURN_Q13     = 18'd51472;

    localparam logic signed [Z_BITS-1:0] ATAN_Q24 [TABLE_LEN] = '{
        29'sd13176795, 29'sd7778716, 29'sd4110060, 29'sd2086331,
        29'sd1047214,  29'sd524117,  29'sd262123,  29'sd131069,
        29'sd65536,    29'sd32768,   29'sd16384,   29'sd8192,
        29'sd4096,     29'sd2048,    29'sd1024,    29'sd512,
        29'sd256,      29'sd128,     29'sd64,      29'sd32,
        29'sd16,       29'sd8,       29'sd4,       29'sd2
    };

    typedef struct packed {
        logic                  valid;
        logic                  special;
        logic [ANGLE_BITS-1:0] spec_angle;
    } t_ctl;

endpackage

FILE: rtl/fcva_prep.sv
// Input stage: axis cases, left half plane fold and guard bit scaling.
// Depends on fcva_pkg and the assertion macro header.
`include "full_circle_vector_angle_unit_macros.svh"

module fcva_prep #(
    parameter int COORD_BITS = 16,
    parameter int W          = 36
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [COORD_BITS-1:0]    i_vec_x,
    input  logic signed [COORD_BITS-1:0]    i_vec_y,
    output fcva_pkg::t_ctl                  o_ctl,
    output logic signed [W-1:0]             o_x,
    output logic signed [W-1:0]             o_y,
    output logic signed [fcva_pkg::Z_BITS-1:0] o_z
);

    logic signed [W-1:0]                  sx;
    logic signed [W-1:0]                  sy;
    logic                                 x_zero;
    logic                                 y_zero;
    fcva_pkg::t_ctl                       n_ctl;
    logic signed [W-1:0]                  n_x;
    logic signed [W-1:0]                  n_y;
    logic signed [fcva_pkg::Z_BITS-1:0]   n_z;
    fcva_pkg::t_ctl                       r_ctl;
    logic signed [W-1:0]                  r_x;
    logic signed [W-1:0]                  r_y;
    logic signed [fcva_pkg::Z_BITS-1:0]   r_z;

    always_comb begin
        sx     = W'(i_vec_x);
        sy     = W'(i_vec_y);
        x_zero = (i_vec_x == '0);
        y_zero = (i_vec_y == '0);
        n_ctl.valid   = i_start;
        n_ctl.special = x_zero || y_zero;
        if (x_zero) begin
            if (y_zero) begin
                n_ctl.spec_angle = fcva_pkg::ZERO_Q13;
            end else if (i_vec_y[COORD_BITS-1]) begin
                n_ctl.spec_angle = fcva_pkg::THREE_HALF_PI_Q13;
            end else begin
                n_ctl.spec_angle = fcva_pkg::HALF_PI_Q13;
            end
        end else if (i_vec_x[COORD_BITS-1]) begin
            n_ctl.spec_angle = fcva_pkg::PI_Q13;
        end else begin
            n_ctl.spec_angle = fcva_pkg::ZERO_Q13;
        end
        if (i_vec_x[COORD_BITS-1]) begin
            n_x = (-sx) <<< fcva_pkg::GUARD_SHIFT;
            n_y = (-sy) <<< fcva_pkg::GUARD_SHIFT;
            n_z = fcva_pkg::PI_Q24;
        end else begin
            n_x = sx <<< fcva_pkg::GUARD_SHIFT;
            n_y = sy <<< fcva_pkg::GUARD_SHIFT;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

    `FCVA_ASSERT_IMPL(a_prep_fold, i_clk, i_rst_n, r_ctl.valid && !r_ctl.special, (r_x > 0) && ((r_z == '0) || (r_z == fcva_pkg::PI_Q24)))

endmodule

FILE: rtl/fcva_cell.sv
// One vectoring CORDIC cell: a fixed shift, add or subtract, and arctangent step.
// Depends on fcva_pkg and the assertion macro header.
`include "full_circle_vector_angle_unit_macros.svh"

module fcva_cell #(
    parameter int W         = 36,
    parameter int STAGE_IDX = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fcva_pkg::t_ctl                     i_ctl,
    input  logic signed [W-1:0]                i_x,
    input  logic signed [W-1:0]                i_y,
    input  logic signed [fcva_pkg::Z_BITS-1:0] i_z,
    output fcva_pkg::t_ctl                     o_ctl,
    output logic signed [W-1:0]                o_x,
    output logic signed [W-1:0]                o_y,
    output logic signed [fcva_pkg::Z_BITS-1:0] o_z
);

    localparam logic signed [fcva_pkg::Z_BITS-1:0] ATAN = fcva_pkg::ATAN_Q24[STAGE_IDX];

    logic signed [W-1:0]                  xs;
    logic signed [W-1:0]                  ys;
    logic signed [W-1:0]                  n_x;
    logic signed [W-1:0]                  n_y;
    logic signed [fcva_pkg::Z_BITS-1:0]   n_z;
    fcva_pkg::t_ctl                       r_ctl;
    logic signed [W-1:0]                  r_x;
    logic signed [W-1:0]                  r_y;
    logic signed [fcva_pkg::Z_BITS-1:0]   r_z;

    always_comb begin
        xs = i_x >>> STAGE_IDX;
        ys = i_y >>> STAGE_IDX;
        if (!i_y[W-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

    `FCVA_ASSERT_IMPL(a_cell_x_pos, i_clk, i_rst_n, r_ctl.valid && !r_ctl.special, r_x > 0)
    `FCVA_ASSERT_NEXT(a_cell_special, i_clk, i_rst_n, i_ctl.valid && i_ctl.special, r_ctl.valid && r_ctl.special && (r_ctl.spec_angle == $past(i_ctl.spec_angle)))

endmodule

FILE: rtl/fcva_post.sv
// Output stage: wrap into the full turn and round to 13 fractional bits, or take the axis angle; register result.
// Depends on fcva_pkg.
module fcva_post (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  fcva_pkg::t_ctl                        i_ctl,
    input  logic signed [fcva_pkg::Z_BITS-1:0]    i_z,
    output logic                                  o_valid,
    output logic [fcva_pkg::ANGLE_BITS-1:0]       o_angle_rad
);

    logic signed [fcva_pkg::Z_BITS-1:0]  z_plain;
    logic signed [fcva_pkg::Z_BITS-1:0]  z_wrap;
    logic signed [fcva_pkg::Z_BITS-1:0]  z_rnd;
    logic [fcva_pkg::Q_BITS-1:0]         q;
    logic [fcva_pkg::ANGLE_BITS-1:0]     n_angle;
    logic                                r_valid;
    logic [fcva_pkg::ANGLE_BITS-1:0]     r_angle;

    always_comb begin
        z_plain = i_z + fcva_pkg::ROUND_BIAS;
        z_wrap  = i_z + fcva_pkg::TWO_PI_Q24 + fcva_pkg::ROUND_BIAS;
        z_rnd   = i_z[fcva_pkg::Z_BITS-1] ? z_wrap : z_plain;
        q       = z_rnd[fcva_pkg::Z_BITS-1:fcva_pkg::ROUND_SHIFT];
        if (i_ctl.special) begin
            n_angle = i_ctl.spec_angle;
        end else if (q >= fcva_pkg::FULL_TURN_Q13) begin
            n_angle = fcva_pkg::ZERO_Q13;
        end else begin
            n_angle = q[fcva_pkg::ANGLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
        r_angle <= n_angle;
    end

    assign o_valid     = r_valid;
    assign o_angle_rad = r_angle;

endmodule

FILE: rtl/full_circle_vector_angle_unit.sv
// Full circle vector angle unit: angle of a signed vector (x, y), 0 to below 2*pi,
// as radians times 8192, by a chain of vectoring CORDIC cells.
// Depends on fcva_pkg, fcva_prep, fcva_cell, fcva_post and the assertion macro header.
// An item is taken at a rising edge where start is high and busy is low; busy is
// always low, so a new vector may be offered in every cycle.
// The result appears on o_angle_rad with o_valid high for exactly one cycle,
// after one input register, one register per CORDIC cell and one rounding
// register. Throughput is one item per cycle, set by the fully unrolled cell
// chain.
// Items leave in the order they entered; the receiver cannot stall.
// A synchronous reset clears the valid bits along the chain, so items in flight
// are dropped; the data registers are not reset.
`include "full_circle_vector_angle_unit_macros.svh"

module full_circle_vector_angle_unit #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic signed [COORD_BITS-1:0]        i_vec_x,
    input  logic signed [COORD_BITS-1:0]        i_vec_y,
    output logic                                busy,
    output logic                                o_valid,
    output logic [fcva_pkg::ANGLE_BITS-1:0]     o_angle_rad
);

    localparam int N = (CORDIC_STAGES < fcva_pkg::TABLE_LEN) ?
                       CORDIC_STAGES : fcva_pkg::TABLE_LEN;
    localparam int W = COORD_BITS + 20;

    fcva_pkg::t_ctl                       ctl [N+1];
    logic signed [W-1:0]                  cx  [N+1];
    logic signed [W-1:0]                  cy  [N+1];
    logic signed [fcva_pkg::Z_BITS-1:0]   cz  [N+1];

    assign busy = 1'b0;

    fcva_prep #(
        .COORD_BITS (COORD_BITS),
        .W          (W)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start & ~busy),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .o_ctl   (ctl[0]),
        .o_x     (cx[0]),
        .o_y     (cy[0]),
        .o_z     (cz[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        fcva_cell #(
            .W         (W),
            .STAGE_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[g]),
            .i_x     (cx[g]),
            .i_y     (cy[g]),
            .i_z     (cz[g]),
            .o_ctl   (ctl[g+1]),
            .o_x     (cx[g+1]),
            .o_y     (cy[g+1]),
            .o_z     (cz[g+1])
        );
    end

    fcva_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl[N]),
        .i_z         (cz[N]),
        .o_valid     (o_valid),
        .o_angle_rad (o_angle_rad)
    );

    `FCVA_ASSERT_IMPL(a_top_range, i_clk, i_rst_n, o_valid, o_angle_rad < fcva_pkg::FULL_TURN_Q13[fcva_pkg::ANGLE_BITS-1:0])

endmodule
